// ----- hw/rtl/bff_pkg.sv -----
// bff_pkg: shared widths, command codes and sequencer states of the bitmap find-first block
// no dependencies
`timescale 1ns / 1ps

package bff_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 10;
  localparam int CFG_W  = 11;
  localparam int BASE_W = CFG_W + 1;

  localparam int DEF_MAX_BITS  = 1024;
  localparam int DEF_WORD_BITS = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FIND  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_LOAD,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/bff_ifs.sv -----
// bff_ifs: request, response and configuration channels of the bitmap find-first block
// depends on bff_pkg
`timescale 1ns / 1ps

interface bff_req_if;
  import bff_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] bit_index;
  logic             bit_value;
  modport source (output valid, cmd, bit_index, bit_value, input ready);
  modport sink   (input valid, cmd, bit_index, bit_value, output ready);
endinterface

interface bff_rsp_if;
  import bff_pkg::*;
  logic             valid;
  logic             ready;
  logic             read_bit;
  logic             found;
  logic [IDX_W-1:0] found_index;
  modport source (output valid, read_bit, found, found_index, input ready);
  modport sink   (input valid, read_bit, found, found_index, output ready);
endinterface

interface bff_cfg_if;
  import bff_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/bitmap_find_first.sv -----
// bitmap_find_first: bit store with read, write and find-first-match under a small sequencer
// depends on bff_pkg and the channel interfaces in bff_ifs
`timescale 1ns / 1ps
//
// usage
// - req channel: cmd (read, write, find), bit_index, bit_value; one request at a time
// - rsp channel: read_bit, found, found_index; exactly one response per request
// - cfg channel: bits_in_use, always ready; write it only while the block is idle
// - the word index and bit offset come from a reciprocal multiply and one correction step
// - read and write: after DIV, FIX, LOAD and EXEC, DONE registers the response
// - find: after DIV, FIX and LOAD, SCAN reads one word per cycle, set by the single memory
//   read port (up to 32 words at the defaults), then DONE and back to IDLE
// - requests outside bits_in_use or with the unused command answer with all fields zero
// - reset: a clearing pass writes zero to every word, one word a cycle, MAX_BITS/WORD_BITS
//   words (32 at the defaults); req.ready stays low meanwhile, cfg writes are taken
// - rsp stall: the response sits in its output register; the next request is still
//   accepted and worked on, and its result waits until the output register is free

module bitmap_find_first #(
  parameter int MAX_BITS  = bff_pkg::DEF_MAX_BITS,
  parameter int WORD_BITS = bff_pkg::DEF_WORD_BITS
) (
  input logic     clk,
  input logic     rst,
  bff_req_if.sink   req,
  bff_rsp_if.source rsp,
  bff_cfg_if.sink   cfg
);
  import bff_pkg::*;

  localparam int NUM_WORDS   = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int OFF_W       = $clog2(WORD_BITS);
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;
  localparam int PROD_W      = IDX_W + RECIP_SHIFT;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;

  state_t state, state_next;

  logic [CFG_W-1:0]  bits_in_use;
  logic [CFG_W-1:0]  size;
  logic [BASE_W-1:0] size_ext;

  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  idx;
  logic              val;
  logic              in_range;
  logic [IDX_W-1:0]  q_raw;
  logic [WAW-1:0]    wptr;
  logic [OFF_W-1:0]  lo;
  logic [BASE_W-1:0] base;

  logic              res_read_bit;
  logic              res_found;
  logic [IDX_W-1:0]  res_index;

  logic [PROD_W-1:0]    prod;
  logic [BASE_W-1:0]    qwb;
  logic [BASE_W-1:0]    rem;
  logic                 rem_over;
  logic [BASE_W-1:0]    left;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] hit_oh;
  logic [OFF_W-1:0]     hit_k;
  logic                 hit;
  logic                 last_word;
  logic                 fix_skip;
  logic                 out_free;

  // active size and index arithmetic
  always_comb begin
    size     = (32'(bits_in_use) > MAX_BITS) ? CFG_W'(MAX_BITS) : bits_in_use;
    size_ext = BASE_W'(size);
    prod     = PROD_W'(idx) * PROD_W'(RECIP);
    qwb      = BASE_W'(q_raw) * BASE_W'(WORD_BITS);
    rem      = BASE_W'(idx) - qwb;
    rem_over = rem >= BASE_W'(WORD_BITS);
    fix_skip = !in_range || !(cmd inside {CMD_READ, CMD_WRITE, CMD_FIND});
    out_free = !rsp.valid || rsp.ready;
  end

  // word scan: mask, then lowest set bit
  always_comb begin
    cand = val ? rdata : ~rdata;
    cand = cand & ({WORD_BITS{1'b1}} << lo);
    left = size_ext - base;
    if (left < BASE_W'(WORD_BITS)) begin
      cand = cand & ~({WORD_BITS{1'b1}} << left[OFF_W-1:0]);
    end
    hit_oh = cand & (~cand + 1'b1);
    hit_k  = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (hit_oh[i]) begin
        hit_k = hit_k | OFF_W'(i);
      end
    end
    hit       = |cand;
    last_word = (base + BASE_W'(WORD_BITS)) >= size_ext;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (32'(wptr) == NUM_WORDS - 1) state_next = ST_IDLE;
      ST_IDLE:  if (req.valid) state_next = ST_DIV;
      ST_DIV:   state_next = ST_FIX;
      ST_FIX:   state_next = fix_skip ? ST_DONE : ST_LOAD;
      ST_LOAD:  state_next = (cmd == CMD_FIND) ? ST_SCAN : ST_EXEC;
      ST_EXEC:  state_next = ST_DONE;
      ST_SCAN:  if (hit || last_word) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = 1'b0;
    cfg.ready = 1'b1;
    mem_we    = 1'b0;
    mem_wdata = rdata;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_IDLE: req.ready = 1'b1;
      ST_EXEC: begin
        mem_we        = (cmd == CMD_WRITE);
        mem_wdata[lo] = val;
      end
      default: ;
    endcase
  end

  // bit store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr] <= mem_wdata;
    end
    rdata <= mem[wptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      wptr        <= '0;
      bits_in_use <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        bits_in_use <= cfg.data;
      end
      case (state)
        ST_CLEAR: wptr <= wptr + 1'b1;
        ST_IDLE: begin
          cmd          <= req.cmd;
          idx          <= req.bit_index;
          val          <= req.bit_value;
          res_read_bit <= 1'b0;
          res_found    <= 1'b0;
          res_index    <= '0;
        end
        ST_DIV: begin
          q_raw    <= prod[RECIP_SHIFT +: IDX_W];
          in_range <= BASE_W'(idx) < size_ext;
        end
        ST_FIX: begin
          if (rem_over) begin
            wptr <= WAW'(q_raw + 1'b1);
            lo   <= OFF_W'(rem - BASE_W'(WORD_BITS));
            base <= qwb + BASE_W'(WORD_BITS);
          end else begin
            wptr <= WAW'(q_raw);
            lo   <= OFF_W'(rem);
            base <= qwb;
          end
        end
        ST_LOAD: if (cmd == CMD_FIND) wptr <= wptr + 1'b1;
        ST_EXEC: res_read_bit <= (cmd == CMD_READ) & rdata[lo];
        ST_SCAN: begin
          if (hit) begin
            res_found <= 1'b1;
            res_index <= IDX_W'(base + BASE_W'(hit_k));
          end else begin
            base <= base + BASE_W'(WORD_BITS);
            lo   <= '0;
            wptr <= wptr + 1'b1;
          end
        end
        default: ;
      endcase
      if (state == ST_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rsp.read_bit    <= res_read_bit;
      rsp.found       <= res_found;
      rsp.found_index <= res_index;
    end
  end

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_EXEC))
    else $error("bit store written outside clear pass or write step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_DIV))
    else $error("accepted request did not start the sequencer");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.found_index == '0))
    else $error("nonzero index without a match");

  a_read_vs_find: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.read_bit) |-> !rsp.found)
    else $error("read bit and found flag both set");

endmodule

// ----- sim/tb.sv -----
// tb: self-checking testbench of bitmap_find_first, with directed and random requests
// keeps a shadow bitmap to predict each response; needs bff_pkg, bff_ifs and the block
`timescale 1ns / 1ps

module tb;
  import bff_pkg::*;

  localparam int MAX_BITS = DEF_MAX_BITS;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic             read_bit;
    logic             found;
    logic [IDX_W-1:0] found_index;
  } bff_result_t;

  logic clk = 1'b0;
  logic rst;

  bff_req_if req_if ();
  bff_rsp_if rsp_if ();
  bff_cfg_if cfg_if ();

  bitmap_find_first dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [MAX_BITS-1:0] shadow_bits = '0;
  logic [CFG_W-1:0]    shadow_size = '0;
  bff_result_t         answers_due[$];

  int errors = 0;
  int req_gap_max = 0;
  int rsp_stall_max = 0;
  int n_reads = 0, n_writes = 0, n_finds = 0, n_hits = 0, n_spare = 0, n_sizes = 0;

  function automatic int active_bits();
    return (int'(shadow_size) > MAX_BITS) ? MAX_BITS : int'(shadow_size);
  endfunction

  // applies one request to the shadow bitmap and returns the response it should give
  function automatic bff_result_t bitmap_answer(input logic [CMD_W-1:0] c,
                                                input logic [IDX_W-1:0] i, input logic v);
    bff_result_t r;
    int lim;
    r = '0;
    lim = active_bits();
    if (int'(i) < lim) begin
      case (c)
        CMD_READ: begin
          r.read_bit = shadow_bits[i];
        end
        CMD_WRITE: begin
          shadow_bits[i] = v;
        end
        CMD_FIND: begin
          for (int k = int'(i); k < lim && !r.found; k++) begin
            if (shadow_bits[k] == v) begin
              r.found = 1'b1;
              r.found_index = IDX_W'(k);
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [IDX_W-1:0] want,
                                 input logic [IDX_W-1:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic send_request(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] i,
                              input logic v);
    int gap;
    bff_result_t r;
    gap = $urandom_range(0, req_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= c;
    req_if.bit_index <= i;
    req_if.bit_value <= v;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    r = bitmap_answer(c, i, v);
    answers_due.push_back(r);
    case (c)
      CMD_READ:  n_reads++;
      CMD_WRITE: n_writes++;
      CMD_FIND:  n_finds++;
      default:   n_spare++;
    endcase
    if (r.found) n_hits++;
  endtask

  // stop sending and let every outstanding response come back
  task automatic drain();
    int waited;
    @(negedge clk);
    req_if.valid <= 1'b0;
    waited = 0;
    while (answers_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] n);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= n;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    shadow_size = n;
    n_sizes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    req_gap_max = 0;
    rsp_stall_max = 0;
    write_size(CFG_W'(MAX_BITS));
    send_request(CMD_READ, 10'd0, 1'b0);
    send_request(CMD_READ, 10'd1023, 1'b0);
    send_request(CMD_FIND, 10'd0, 1'b1);
    send_request(CMD_FIND, 10'd1023, 1'b0);
    drain();
  endtask

  task automatic test_read_write();
    req_gap_max = 13;
    rsp_stall_max = 13;
    send_request(CMD_WRITE, 10'd0, 1'b1);
    send_request(CMD_WRITE, 10'd1023, 1'b1);
    send_request(CMD_READ, 10'd0, 1'b0);
    send_request(CMD_READ, 10'd1023, 1'b0);
    send_request(CMD_WRITE, 10'd1023, 1'b0);
    send_request(CMD_READ, 10'd1023, 1'b1);
    send_request(CMD_SPARE, 10'd1023, 1'b1);
    drain();
  endtask

  task automatic test_size_edges();
    req_gap_max = 3;
    rsp_stall_max = 3;
    // partial last word
    write_size(11'd33);
    send_request(CMD_WRITE, 10'd32, 1'b1);
    send_request(CMD_WRITE, 10'd33, 1'b1);
    send_request(CMD_FIND, 10'd1, 1'b1);
    send_request(CMD_READ, 10'd33, 1'b0);
    send_request(CMD_FIND, 10'd33, 1'b0);
    drain();
    // empty bitmap
    write_size(11'd0);
    send_request(CMD_READ, 10'd0, 1'b0);
    send_request(CMD_FIND, 10'd0, 1'b0);
    drain();
    // size above capacity
    write_size(11'd2047);
    send_request(CMD_WRITE, 10'd1023, 1'b1);
    send_request(CMD_FIND, 10'd33, 1'b1);
    send_request(CMD_FIND, 10'd0, 1'b0);
    drain();
    write_size(11'd1);
    send_request(CMD_FIND, 10'd0, 1'b0);
    send_request(CMD_READ, 10'd0, 1'b0);
    drain();
  endtask

  task automatic test_random(input int phases, input int per_phase);
    logic [CFG_W-1:0] sizes[7] = '{11'd1, 11'd31, 11'd32, 11'd33, 11'd1023, 11'd1024, 11'd2047};
    int lim, ones_pct, r;
    logic [CMD_W-1:0] c;
    logic [IDX_W-1:0] i;
    logic v;
    for (int p = 0; p < phases; p++) begin
      if ($urandom_range(0, 9) < 4)
        write_size(sizes[$urandom_range(0, 6)]);
      else
        write_size(CFG_W'($urandom_range(1, 2047)));
      req_gap_max = $urandom_range(0, 1) ? 13 : 0;
      rsp_stall_max = $urandom_range(0, 1) ? 13 : 0;
      case ($urandom_range(0, 2))
        0: ones_pct = 5;
        1: ones_pct = 50;
        default: ones_pct = 95;
      endcase
      lim = active_bits();
      for (int n = 0; n < per_phase; n++) begin
        r = $urandom_range(0, 99);
        if (r < 30) c = CMD_WRITE;
        else if (r < 55) c = CMD_READ;
        else if (r < 95) c = CMD_FIND;
        else c = CMD_SPARE;
        if (lim > 0 && $urandom_range(0, 9) < 8)
          i = IDX_W'($urandom_range(0, lim - 1));
        else
          i = IDX_W'($urandom_range(0, 1023));
        if (c == CMD_WRITE)
          v = ($urandom_range(0, 99) < ones_pct);
        else
          v = 1'($urandom_range(0, 1));
        send_request(c, i, v);
      end
      drain();
    end
  endtask

  initial begin : response_check
    bff_result_t got, want;
    int stall;
    rsp_if.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, rsp_stall_max);
      @(negedge clk);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (rsp_if.valid !== 1'b1 || rst) @(posedge clk);
      got = {rsp_if.read_bit, rsp_if.found, rsp_if.found_index};
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: response with no request pending", $time);
      end else begin
        want = answers_due.pop_front();
        if (got.read_bit !== want.read_bit)
          report_mismatch("read_bit", IDX_W'(want.read_bit), IDX_W'(got.read_bit));
        if (got.found !== want.found)
          report_mismatch("found", IDX_W'(want.found), IDX_W'(got.found));
        if (got.found_index !== want.found_index)
          report_mismatch("found_index", want.found_index, got.found_index);
      end
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_READ;
    req_if.bit_index = '0;
    req_if.bit_value = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_read_write();
    test_size_edges();
    test_random(20, 100);

    if (answers_due.size() != 0) begin
      errors++;
      $display("%0t: %0d responses never arrived", $time, answers_due.size());
    end
    $display("covered %0d reads, %0d writes, %0d searches (%0d hits), %0d unused commands",
             n_reads, n_writes, n_finds, n_hits, n_spare);
    $display("over %0d bits_in_use settings, with and without idle cycles", n_sizes);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- bitmap_find_first.f -----
hw/rtl/bff_pkg.sv
hw/rtl/bff_ifs.sv
hw/rtl/bitmap_find_first.sv
sim/tb.sv
